// ===== src/nrsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrsa_pkg
// Shared widths, register codes and request/response types for the
// nearest-neighbor resize source address generator.
// ----------------------------------------------------------------------------
package nrsa_pkg;

   localparam int DIM_BITS       = 16;
   localparam int OFFSET_BITS    = 48;
   localparam int STRIDE_BITS    = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   // dividend (2*o+1)*in and divisor 2*out
   localparam int NUM_BITS      = 2 * DIM_BITS + 1;
   localparam int DEN_BITS      = DIM_BITS + 1;
   localparam int PROD_BITS     = DIM_BITS + STRIDE_BITS;

   // quotient bits resolved per divider stage
   localparam int STEP_BITS     = 2;
   localparam int DIV_STAGES    = (DIM_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int BIT_IDX_BITS  = $clog2(DIM_BITS);

   localparam logic [DIM_BITS-1:0]    RST_IN_HEIGHT      = DIM_BITS'(1);
   localparam logic [DIM_BITS-1:0]    RST_IN_WIDTH       = DIM_BITS'(1);
   localparam logic [DIM_BITS-1:0]    RST_OUT_HEIGHT     = DIM_BITS'(1);
   localparam logic [DIM_BITS-1:0]    RST_OUT_WIDTH      = DIM_BITS'(1);
   localparam logic [STRIDE_BITS-1:0] RST_STRIDE_BATCH   = STRIDE_BITS'(0);
   localparam logic [STRIDE_BITS-1:0] RST_STRIDE_CHANNEL = STRIDE_BITS'(0);
   localparam logic [STRIDE_BITS-1:0] RST_STRIDE_ROW     = STRIDE_BITS'(0);
   localparam logic [STRIDE_BITS-1:0] RST_STRIDE_COLUMN  = STRIDE_BITS'(1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IN_HEIGHT      = 3'd0,
      CSR_IN_WIDTH       = 3'd1,
      CSR_OUT_HEIGHT     = 3'd2,
      CSR_OUT_WIDTH      = 3'd3,
      CSR_STRIDE_BATCH   = 3'd4,
      CSR_STRIDE_CHANNEL = 3'd5,
      CSR_STRIDE_ROW     = 3'd6,
      CSR_STRIDE_COLUMN  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] batch_index;
      logic [DIM_BITS-1:0] channel_index;
      logic [DIM_BITS-1:0] out_row;
      logic [DIM_BITS-1:0] out_column;
   } req_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]    src_row;
      logic [DIM_BITS-1:0]    src_column;
      logic [OFFSET_BITS-1:0] src_offset;
      logic                   coord_outside;
   } rsp_type;

endpackage

// ===== src/nrsa_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrsa_div_pipe
// Pipelined restoring divider, STEP_BITS quotient bits per stage. Assumes
// the quotient fits in DIM_BITS (dividend < divisor * 2**DIM_BITS).
// ----------------------------------------------------------------------------
module nrsa_div_pipe (
   input  logic                                clock,
   input  logic [nrsa_pkg::NUM_BITS-1:0]       dividend,
   input  logic [nrsa_pkg::DEN_BITS-1:0]       divisor,
   input  logic [nrsa_pkg::DIV_STAGES-1:0]     stage_en,
   output logic [nrsa_pkg::DIM_BITS-1:0]       quotient
);
   import nrsa_pkg::*;

   logic [DEN_BITS-1:0] rem_src  [DIV_STAGES];
   logic [DIM_BITS-1:0] low_src  [DIV_STAGES];
   logic [DIM_BITS-1:0] quot_src [DIV_STAGES];
   logic [DEN_BITS-1:0] den_src  [DIV_STAGES];

   logic [DEN_BITS-1:0] rem_in   [DIV_STAGES];
   logic [DIM_BITS-1:0] quot_in  [DIV_STAGES];

   logic [DEN_BITS-1:0] rem_ff   [DIV_STAGES];
   logic [DIM_BITS-1:0] low_ff   [DIV_STAGES];
   logic [DIM_BITS-1:0] quot_ff  [DIV_STAGES];
   logic [DEN_BITS-1:0] den_ff   [DIV_STAGES];

   always_comb begin
      rem_src[0]  = dividend[NUM_BITS-1:DIM_BITS];
      low_src[0]  = dividend[DIM_BITS-1:0];
      quot_src[0] = '0;
      den_src[0]  = divisor;
      for (int s = 1; s < DIV_STAGES; s++) begin
         rem_src[s]  = rem_ff[s-1];
         low_src[s]  = low_ff[s-1];
         quot_src[s] = quot_ff[s-1];
         den_src[s]  = den_ff[s-1];
      end
   end

   always_comb begin
      logic [DEN_BITS:0]   trial;
      logic [DEN_BITS-1:0] rem;
      logic [DIM_BITS-1:0] quot;
      int                  bit_idx;
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem  = rem_src[s];
         quot = quot_src[s];
         for (int j = 0; j < STEP_BITS; j++) begin
            bit_idx = DIM_BITS - 1 - s * STEP_BITS - j;
            if (bit_idx >= 0) begin
               trial = {rem, low_src[s][bit_idx[BIT_IDX_BITS-1:0]]};
               if (trial >= {1'b0, den_src[s]}) begin
                  rem = DEN_BITS'(trial - {1'b0, den_src[s]});
                  quot[bit_idx[BIT_IDX_BITS-1:0]] = 1'b1;
               end else begin
                  rem = trial[DEN_BITS-1:0];
               end
            end
         end
         rem_in[s]  = rem;
         quot_in[s] = quot;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (stage_en[s]) begin
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
            low_ff[s]  <= low_src[s];
            den_ff[s]  <= den_src[s];
         end
      end
   end

   assign quotient = quot_ff[DIV_STAGES-1];

endmodule

// ===== src/nearest_resize_source_address.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_resize_source_address
// Source row/column and strided source offset for a half-pixel nearest
// resize of a 4D tensor, one request per cycle while rsp_ready allows.
//
//   channel  dir  handshake               payload
//   req      in   req_valid/req_ready     req_data  (nrsa_pkg::req_type)
//   rsp      out  rsp_valid/rsp_ready     rsp_data  (nrsa_pkg::rsp_type)
//   csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// Registered stages: dividends and products, the divider pipeline, select,
// add and output; throughput one request per cycle while rsp_ready allows.
// Synchronous reset empties the pipeline and loads register defaults.
// Each stage holds under back-pressure and bubbles are squeezed out.
// ----------------------------------------------------------------------------
module nearest_resize_source_address (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  nrsa_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output nrsa_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nrsa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [nrsa_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import nrsa_pkg::*;

   localparam int S_SEL      = DIV_STAGES + 1;
   localparam int S_ADD      = DIV_STAGES + 2;
   localparam int S_OUT      = DIV_STAGES + 3;
   localparam int NUM_STAGES = DIV_STAGES + 4;

   typedef struct packed {
      logic                   row_out;
      logic                   col_out;
      logic [OFFSET_BITS-1:0] bc_sum;
   } side_type;

   // configuration
   logic [DIM_BITS-1:0]    in_height_ff, in_width_ff, out_height_ff, out_width_ff;
   logic [STRIDE_BITS-1:0] stride_batch_ff, stride_channel_ff;
   logic [STRIDE_BITS-1:0] stride_row_ff, stride_column_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff      <= RST_IN_HEIGHT;
         in_width_ff       <= RST_IN_WIDTH;
         out_height_ff     <= RST_OUT_HEIGHT;
         out_width_ff      <= RST_OUT_WIDTH;
         stride_batch_ff   <= RST_STRIDE_BATCH;
         stride_channel_ff <= RST_STRIDE_CHANNEL;
         stride_row_ff     <= RST_STRIDE_ROW;
         stride_column_ff  <= RST_STRIDE_COLUMN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_IN_HEIGHT:      in_height_ff      <= DIM_BITS'(csr_data);
            CSR_IN_WIDTH:       in_width_ff       <= DIM_BITS'(csr_data);
            CSR_OUT_HEIGHT:     out_height_ff     <= DIM_BITS'(csr_data);
            CSR_OUT_WIDTH:      out_width_ff      <= DIM_BITS'(csr_data);
            CSR_STRIDE_BATCH:   stride_batch_ff   <= STRIDE_BITS'(csr_data);
            CSR_STRIDE_CHANNEL: stride_channel_ff <= STRIDE_BITS'(csr_data);
            CSR_STRIDE_ROW:     stride_row_ff     <= STRIDE_BITS'(csr_data);
            CSR_STRIDE_COLUMN:  stride_column_ff  <= STRIDE_BITS'(csr_data);
            default: ;
         endcase
      end
   end

   // stage valids and flow control
   logic [NUM_STAGES-1:0] v_ff, v_in, load;
   logic [NUM_STAGES:0]   rdy;

   always_comb begin
      rdy[NUM_STAGES] = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      v_in[0] = rdy[0] ? req_valid : v_ff[0];
      load[0] = rdy[0] && req_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
         load[k] = rdy[k] && v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = v_ff[S_OUT];

   // stage 0: dividends and batch/channel products
   logic [NUM_BITS-1:0]    num_row_s0_ff, num_col_s0_ff;
   logic [OFFSET_BITS-1:0] prod_b_s0_ff, prod_c_s0_ff;
   logic                   row_out_s0_ff, col_out_s0_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         num_row_s0_ff <= NUM_BITS'({req_data.out_row, 1'b1}) * NUM_BITS'(in_height_ff);
         num_col_s0_ff <= NUM_BITS'({req_data.out_column, 1'b1}) * NUM_BITS'(in_width_ff);
         prod_b_s0_ff  <= OFFSET_BITS'(PROD_BITS'(req_data.batch_index)
                                       * PROD_BITS'(stride_batch_ff));
         prod_c_s0_ff  <= OFFSET_BITS'(PROD_BITS'(req_data.channel_index)
                                       * PROD_BITS'(stride_channel_ff));
         row_out_s0_ff <= req_data.out_row >= out_height_ff;
         col_out_s0_ff <= req_data.out_column >= out_width_ff;
      end
   end

   // stages 1..DIV_STAGES: dividers with sideband
   logic [DIM_BITS-1:0] quot_row, quot_col;
   side_type            sb_ff [DIV_STAGES];

   nrsa_div_pipe u_div_row (
      .clock    (clock),
      .dividend (num_row_s0_ff),
      .divisor  ({out_height_ff, 1'b0}),
      .stage_en (load[DIV_STAGES:1]),
      .quotient (quot_row)
   );

   nrsa_div_pipe u_div_col (
      .clock    (clock),
      .dividend (num_col_s0_ff),
      .divisor  ({out_width_ff, 1'b0}),
      .stage_en (load[DIV_STAGES:1]),
      .quotient (quot_col)
   );

   always_ff @(posedge clock) begin
      if (load[1]) begin
         sb_ff[0].row_out <= row_out_s0_ff;
         sb_ff[0].col_out <= col_out_s0_ff;
         sb_ff[0].bc_sum  <= prod_b_s0_ff + prod_c_s0_ff;
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
         if (load[s+1]) begin
            sb_ff[s] <= sb_ff[s-1];
         end
      end
   end

   // select stage: edge cases, row/column products
   side_type            sb_last;
   logic [DIM_BITS-1:0] src_row_sel, src_col_sel;

   assign sb_last = sb_ff[DIV_STAGES-1];

   always_comb begin
      if (in_height_ff == '0) begin
         src_row_sel = '0;
      end else if (sb_last.row_out) begin
         src_row_sel = in_height_ff - DIM_BITS'(1);
      end else begin
         src_row_sel = quot_row;
      end
      if (in_width_ff == '0) begin
         src_col_sel = '0;
      end else if (sb_last.col_out) begin
         src_col_sel = in_width_ff - DIM_BITS'(1);
      end else begin
         src_col_sel = quot_col;
      end
   end

   logic [DIM_BITS-1:0]    src_row_sel_ff, src_col_sel_ff;
   logic [OFFSET_BITS-1:0] prod_r_sel_ff, prod_w_sel_ff, bc_sel_ff;
   logic                   outside_sel_ff;

   always_ff @(posedge clock) begin
      if (load[S_SEL]) begin
         src_row_sel_ff <= src_row_sel;
         src_col_sel_ff <= src_col_sel;
         prod_r_sel_ff  <= OFFSET_BITS'(PROD_BITS'(src_row_sel) * PROD_BITS'(stride_row_ff));
         prod_w_sel_ff  <= OFFSET_BITS'(PROD_BITS'(src_col_sel)
                                        * PROD_BITS'(stride_column_ff));
         bc_sel_ff      <= sb_last.bc_sum;
         outside_sel_ff <= sb_last.row_out || sb_last.col_out;
      end
   end

   // add stage
   logic [DIM_BITS-1:0]    src_row_add_ff, src_col_add_ff;
   logic [OFFSET_BITS-1:0] rc_add_ff, bc_add_ff;
   logic                   outside_add_ff;

   always_ff @(posedge clock) begin
      if (load[S_ADD]) begin
         src_row_add_ff <= src_row_sel_ff;
         src_col_add_ff <= src_col_sel_ff;
         rc_add_ff      <= prod_r_sel_ff + prod_w_sel_ff;
         bc_add_ff      <= bc_sel_ff;
         outside_add_ff <= outside_sel_ff;
      end
   end

   // output register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (load[S_OUT]) begin
         rsp_ff.src_row       <= src_row_add_ff;
         rsp_ff.src_column    <= src_col_add_ff;
         rsp_ff.src_offset    <= bc_add_ff + rc_add_ff;
         rsp_ff.coord_outside <= outside_add_ff;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.src_row < in_height_ff)
                    || (in_height_ff == '0 && rsp_data.src_row == '0))
      else $error("src_row beyond source height");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.src_column < in_width_ff)
                    || (in_width_ff == '0 && rsp_data.src_column == '0))
      else $error("src_column beyond source width");

   a_inside_needs_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.coord_outside |-> out_height_ff != '0 && out_width_ff != '0)
      else $error("inside flag with empty output size");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

// ===== sim/nearest_resize_source_address_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_resize_source_address_tb
// Self-checking bench for the half-pixel nearest resize source address
// generator. Registers are programmed between phases while the pipeline is
// empty. A scoreboard predicts source row, column, offset and the outside
// flag for every accepted request and checks responses in order. Both
// channels are throttled at random in two of three stages, the last has none.
// ----------------------------------------------------------------------------
module nearest_resize_source_address_tb;

   import nrsa_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 2 * (DIV_STAGES + 4);
   localparam int PHASE_COUNT   = 4;
   localparam int PHASE_ITEMS   = 67;

   class resize_scoreboard;
      logic [DIM_BITS-1:0]    in_height, in_width, out_height, out_width;
      logic [STRIDE_BITS-1:0] stride_batch, stride_channel, stride_row, stride_column;
      rsp_type                expected_q[$];
      int                     error_count;

      function new();
         in_height      = RST_IN_HEIGHT;
         in_width       = RST_IN_WIDTH;
         out_height     = RST_OUT_HEIGHT;
         out_width      = RST_OUT_WIDTH;
         stride_batch   = RST_STRIDE_BATCH;
         stride_channel = RST_STRIDE_CHANNEL;
         stride_row     = RST_STRIDE_ROW;
         stride_column  = RST_STRIDE_COLUMN;
         error_count    = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_IN_HEIGHT:      in_height      = value[DIM_BITS-1:0];
            CSR_IN_WIDTH:       in_width       = value[DIM_BITS-1:0];
            CSR_OUT_HEIGHT:     out_height     = value[DIM_BITS-1:0];
            CSR_OUT_WIDTH:      out_width      = value[DIM_BITS-1:0];
            CSR_STRIDE_BATCH:   stride_batch   = value[STRIDE_BITS-1:0];
            CSR_STRIDE_CHANNEL: stride_channel = value[STRIDE_BITS-1:0];
            CSR_STRIDE_ROW:     stride_row     = value[STRIDE_BITS-1:0];
            CSR_STRIDE_COLUMN:  stride_column  = value[STRIDE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // floor((2*o+1)*in / (2*out)), clamped to in-1; in-1 when o >= out, 0 when in is 0
      function logic [DIM_BITS-1:0] nearest_source(logic [DIM_BITS-1:0] o,
                                                   logic [DIM_BITS-1:0] in_size,
                                                   logic [DIM_BITS-1:0] out_size);
         logic [63:0] num;
         logic [63:0] quot;
         if (in_size == 0) return '0;
         if (o >= out_size) return in_size - DIM_BITS'(1);
         num  = (64'(o) * 2 + 1) * 64'(in_size);
         quot = num / (64'(out_size) * 2);
         if (quot > 64'(in_size - DIM_BITS'(1))) return in_size - DIM_BITS'(1);
         return quot[DIM_BITS-1:0];
      endfunction

      function void note_request(req_type req);
         rsp_type     want;
         logic [63:0] offset;
         want.src_row    = nearest_source(req.out_row, in_height, out_height);
         want.src_column = nearest_source(req.out_column, in_width, out_width);
         offset = 64'(req.batch_index) * 64'(stride_batch)
                + 64'(req.channel_index) * 64'(stride_channel)
                + 64'(want.src_row) * 64'(stride_row)
                + 64'(want.src_column) * 64'(stride_column);
         want.src_offset    = offset[OFFSET_BITS-1:0];
         want.coord_outside = (req.out_row >= out_height) || (req.out_column >= out_width);
         expected_q.push_back(want);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         error_count++;
         $display("mismatch %s: got %h expected %h", what, got, want);
      endtask

      task check_response(rsp_type rsp);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report("unexpected response", 64'(rsp), 64'(0));
         end else begin
            want = expected_q.pop_front();
            if (rsp.src_row !== want.src_row)
               report("src_row", 64'(rsp.src_row), 64'(want.src_row));
            if (rsp.src_column !== want.src_column)
               report("src_column", 64'(rsp.src_column), 64'(want.src_column));
            if (rsp.src_offset !== want.src_offset)
               report("src_offset", 64'(rsp.src_offset), 64'(want.src_offset));
            if (rsp.coord_outside !== want.coord_outside)
               report("coord_outside", 64'(rsp.coord_outside), 64'(want.coord_outside));
         end
      endtask
   endclass

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data  = '0;

   resize_scoreboard board = new();
   int               send_idle_pct = 33;
   int               recv_idle_pct = 57;
   int               cycle_count   = 0;

   nearest_resize_source_address dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL nearest_resize_source_address");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task csr_write(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_register(idx, value);
   endtask

   task program_registers(logic [31:0] ih, logic [31:0] iw, logic [31:0] oh,
                          logic [31:0] ow, logic [31:0] sb, logic [31:0] sc,
                          logic [31:0] sr, logic [31:0] scol);
      csr_write(CSR_IN_HEIGHT, ih);
      csr_write(CSR_IN_WIDTH, iw);
      csr_write(CSR_OUT_HEIGHT, oh);
      csr_write(CSR_OUT_WIDTH, ow);
      csr_write(CSR_STRIDE_BATCH, sb);
      csr_write(CSR_STRIDE_CHANNEL, sc);
      csr_write(CSR_STRIDE_ROW, sr);
      csr_write(CSR_STRIDE_COLUMN, scol);
      csr_valid <= 1'b0;
   endtask

   // valid stays high across back-to-back requests; lowered only for a gap
   task send_request(logic [15:0] b, logic [15:0] c, logic [15:0] r, logic [15:0] w);
      req_type req;
      req.batch_index   = b;
      req.channel_index = c;
      req.out_row       = r;
      req.out_column    = w;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(req);
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
   endtask

   function logic [31:0] pick_dim();
      int roll;
      logic [15:0] dim;
      roll = $urandom_range(99);
      if (roll < 60)      dim = 16'($urandom_range(1, 64));
      else if (roll < 80) dim = 16'($urandom_range(1, 65535));
      else if (roll < 92) dim = ($urandom_range(1)) ? 16'hFFFF : 16'd1;
      else                dim = 16'd0;
      return {($urandom_range(1)) ? 16'($urandom) : 16'h0, dim};
   endfunction

   function logic [31:0] pick_stride();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return 32'($urandom_range(0, 256));
      if (roll < 85) return $urandom;
      return ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
   endfunction

   function logic [15:0] pick_coord(logic [15:0] out_size);
      int roll;
      roll = $urandom_range(99);
      if (roll < 75 && out_size != 0) return 16'($urandom_range(0, out_size - 1));
      if (roll < 85) return out_size;
      return 16'($urandom);
   endfunction

   task random_phase(int kind);
      int n;
      case (kind)
         0: program_registers(32'hFFFF, 32'hFFFF_FFFF, 32'h0001_FFFF, 32'hFFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         1: program_registers(32'h1, 32'hFFFF_0001, 32'h1, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
         default: program_registers(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
                                    pick_stride(), pick_stride(), pick_stride(),
                                    pick_stride());
      endcase
      for (n = 0; n < PHASE_ITEMS; n++)
         send_request(16'($urandom), 16'($urandom),
                      pick_coord(board.out_height), pick_coord(board.out_width));
      wait_drained();
   endtask

   task directed_tests();
      // register defaults straight after reset
      send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      wait_drained();
      // largest sizes and strides
      program_registers(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(16'h0000, 16'hFFFF, 16'h7FFF, 16'h0001);
      wait_drained();
      // upscale 3x5 to 7x11
      program_registers(32'd3, 32'd5, 32'd7, 32'd11, 32'd1000, 32'd100, 32'd5, 32'd1);
      send_request(16'd1, 16'd2, 16'd0, 16'd10);
      send_request(16'd0, 16'd0, 16'd6, 16'd5);
      send_request(16'd3, 16'd1, 16'd7, 16'd3);
      send_request(16'd2, 16'd2, 16'd3, 16'd11);
      wait_drained();
      // output height zero, input width zero (upper data bits dropped)
      program_registers(32'd9, 32'hFFFF_0000, 32'h0, 32'd4, 32'd7, 32'd3, 32'd11, 32'd13);
      send_request(16'd1, 16'd1, 16'd0, 16'd2);
      send_request(16'd5, 16'd0, 16'd4, 16'd3);
      send_request(16'd0, 16'd9, 16'hFFFF, 16'd4);
      wait_drained();
      // strong downscale
      program_registers(32'hFFFF, 32'hFFFF, 32'd3, 32'd2, 32'h8000_0000, 32'h1,
                        32'h0001_0000, 32'h0000_0003);
      send_request(16'h8000, 16'h0001, 16'd0, 16'd0);
      send_request(16'h0001, 16'h8000, 16'd1, 16'd1);
      send_request(16'h7FFF, 16'h00FF, 16'd2, 16'd2);
      wait_drained();
   endtask

   initial begin
      int stage;
      int phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_tests();
      for (stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (phase = 0; phase < PHASE_COUNT; phase++)
            random_phase(phase);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.expected_q.size() != 0)
         board.report("responses missing", 64'(0), 64'(board.expected_q.size()));
      if (board.error_count == 0) begin
         $display("PASS nearest_resize_source_address");
      end else begin
         $display("FAIL nearest_resize_source_address");
      end
      $finish;
   end

endmodule
